FILE: rtl/msd_pkg.sv
// Shared widths, status codes and register indexes for the motor stall detector.
package msd_pkg;

  // default width of timestamps and time differences
  localparam int TIME_BITS_DEF = 32;

  // field widths
  localparam int CUR_BITS    = 16;
  localparam int NOW_BITS    = 32;
  localparam int CFG_BITS    = 32;
  localparam int IDX_BITS    = 3;
  localparam int STATUS_BITS = 3;

  // stream payload widths, rounded up to whole bytes
  localparam int S_DATA_BITS = 48;
  localparam int M_DATA_BITS = 8;

  // item kinds carried in s_tuser
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_RUNNING       = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_NO_MOTOR      = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_STALL         = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_TIMEOUT_STALL = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_TIMEOUT_ERROR = 3'd4;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_STARTUP_IGNORE  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_MOTOR_DETECT    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_STALL_THRESHOLD = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_STALL_CONFIRM   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_TIMEOUT         = 3'd4;

endpackage

FILE: rtl/motor_stall_detector.sv
// Motor stall detector: start/sample stream in, one status beat out per input beat.
//
// Each input beat is a start event or a current sample with a millisecond
// timestamp; each produces exactly one result beat in the cycle after it is taken. The
// detector takes one beat per clock: all checks (a few compares and two
// subtractions modulo 2^TIME_BITS) sit between the detector state and the
// output register, and a new beat is taken whenever the output register is
// empty or being drained in the same cycle (never during reset). Configuration
// writes take effect on the next clock and should be made while no beat is in
// flight.
module motor_stall_detector #(
  parameter int TIME_BITS = msd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [msd_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [msd_pkg::CFG_BITS-1:0]    cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [msd_pkg::S_DATA_BITS-1:0] s_tdata,   // current[15:0], now_ms[47:16]
  input  logic                            s_tuser,   // op (0 start, 1 sample)
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [msd_pkg::M_DATA_BITS-1:0] m_tdata    // status[2:0], active[3], zero[7:4]
);
  import msd_pkg::*;

  typedef logic [TIME_BITS-1:0] tm_t;

  // configuration registers
  logic [CFG_BITS-1:0] startup_ignore_ms;
  logic [CUR_BITS-1:0] motor_detect_ma;
  logic [CUR_BITS-1:0] stall_threshold_ma;
  logic [CFG_BITS-1:0] stall_confirm_ms;
  logic [CFG_BITS-1:0] run_limit_ms;

  // detector state
  tm_t                 start_time, start_time_next;
  logic [CUR_BITS-1:0] peak_current, peak_current_next;
  logic                startup_checked, startup_checked_next;
  logic                confirming, confirming_next;
  tm_t                 confirm_start, confirm_start_next;
  logic                armed, armed_next;

  // output register
  logic                   out_valid;
  logic [STATUS_BITS-1:0] out_status, status_next;
  logic                   out_active;

  // unpacked input beat
  logic                op;
  logic [CUR_BITS-1:0] cur;
  tm_t                 now_t;
  tm_t                 elapsed;
  tm_t                 confirm_elapsed;
  logic                s_fire;
  logic                done;

  assign op     = s_tuser;
  assign cur    = s_tdata[CUR_BITS-1:0];
  assign now_t  = TIME_BITS'(s_tdata[CUR_BITS +: NOW_BITS]);
  assign s_fire = s_tvalid && s_tready;

  assign elapsed         = now_t - start_time;
  assign confirm_elapsed = now_t - confirm_start;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_ignore_ms  <= '0;
      motor_detect_ma    <= '0;
      stall_threshold_ma <= '0;
      stall_confirm_ms   <= '0;
      run_limit_ms       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STARTUP_IGNORE:  startup_ignore_ms  <= cfg_data;
        REG_MOTOR_DETECT:    motor_detect_ma    <= cfg_data[CUR_BITS-1:0];
        REG_STALL_THRESHOLD: stall_threshold_ma <= cfg_data[CUR_BITS-1:0];
        REG_STALL_CONFIRM:   stall_confirm_ms   <= cfg_data;
        REG_TIMEOUT:         run_limit_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // detection decision for the current beat
  always_comb begin
    start_time_next      = start_time;
    peak_current_next    = peak_current;
    startup_checked_next = startup_checked;
    confirming_next      = confirming;
    confirm_start_next   = confirm_start;
    armed_next           = armed;
    status_next          = ST_RUNNING;
    done                 = 1'b0;

    if (op == OP_START) begin
      // (re)arm from this timestamp
      start_time_next      = now_t;
      peak_current_next    = '0;
      startup_checked_next = 1'b0;
      confirming_next      = 1'b0;
      confirm_start_next   = '0;
      armed_next           = 1'b1;
    end else if (armed) begin
      if (elapsed <= TIME_BITS'(startup_ignore_ms)) begin
        // startup window: track peak only
        if (cur > peak_current) peak_current_next = cur;
      end else begin
        // one-time presence check after the window
        if (!startup_checked) begin
          startup_checked_next = 1'b1;
          if (peak_current < motor_detect_ma) begin
            armed_next  = 1'b0;
            status_next = ST_NO_MOTOR;
            done        = 1'b1;
          end
        end
        // stall confirmation
        if (!done) begin
          if (cur > stall_threshold_ma) begin
            if (!confirming) begin
              confirming_next    = 1'b1;
              confirm_start_next = now_t;
            end else if (confirm_elapsed >= TIME_BITS'(stall_confirm_ms)) begin
              armed_next  = 1'b0;
              status_next = ST_STALL;
              done        = 1'b1;
            end
          end else begin
            confirming_next = 1'b0;
          end
        end
        // run timeout
        if (!done && (elapsed > TIME_BITS'(run_limit_ms))) begin
          armed_next  = 1'b0;
          status_next = confirming_next ? ST_TIMEOUT_STALL : ST_TIMEOUT_ERROR;
        end
      end
    end
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time      <= '0;
      peak_current    <= '0;
      startup_checked <= 1'b0;
      confirming      <= 1'b0;
      confirm_start   <= '0;
      armed           <= 1'b0;
    end else if (s_fire) begin
      start_time      <= start_time_next;
      peak_current    <= peak_current_next;
      startup_checked <= startup_checked_next;
      confirming      <= confirming_next;
      confirm_start   <= confirm_start_next;
      armed           <= armed_next;
    end
  end

  // output register; refilled in the cycle it drains, no intake during reset
  assign s_tready = !rst && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_status <= status_next;
      out_active <= armed_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_BITS - STATUS_BITS - 1){1'b0}}, out_active, out_status};

  // a freshly loaded result reports the armed flag left behind by its beat
  a_active_tracks_armed: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (out_active == armed))
    else $error("result active flag differs from detector armed state");

  // a start beat always leaves the detector armed
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (op == OP_START)) |=> armed)
    else $error("start beat did not arm the detector");

  // stall confirmation only runs after the presence check
  a_confirm_after_check: assert property (@(posedge clk) disable iff (rst)
    confirming |-> startup_checked)
    else $error("confirming without startup check");

  // any terminal status ends the run
  a_terminal_inactive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_RUNNING)) |-> !out_active)
    else $error("terminal status reported with detector still active");

endmodule

FILE: verif/tb_motor_stall_detector.sv
`timescale 1ns / 1ps
// Testbench for the motor stall detector: directed table, then random runs checked by a predictor.
module tb_motor_stall_detector;
  import msd_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_BEATS    = 45;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_ROWS       = 24;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic                   active;
  } result_t;

  // one input beat, with an optional hand-written expectation
  typedef struct packed {
    logic                   op;
    logic [CUR_BITS-1:0]    cur;
    logic [NOW_BITS-1:0]    now;
    logic                   typed;
    logic [STATUS_BITS-1:0] exp_status;
    logic                   exp_active;
  } beat_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_BITS-1:0]    cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata   = '0;  // current[15:0], now_ms[47:16]
  logic                   s_tuser   = 1'b0; // op
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_DATA_BITS-1:0] m_tdata;          // status[2:0], active[3], zero[7:4]

  // stimulus and scoreboard storage
  beat_t   send_q[$];
  result_t pending_status[$];
  beat_t   cur_beat = '0;
  beat_t   dir_tab [DIR_ROWS];
  int      mismatch_cnt = 0;
  int      idle_cycles  = 0;
  int      src_idle_pct = 0;
  int      snk_stall_pct = 0;
  logic    hold_go = 1'b0;

  // predictor copy of the registers
  logic [31:0] cfg_ignore  = '0;
  logic [15:0] cfg_detect  = '0;
  logic [15:0] cfg_thresh  = '0;
  logic [31:0] cfg_confirm = '0;
  logic [31:0] cfg_timeout = '0;

  // predictor copy of the detector state
  logic [31:0] p_start      = '0;
  logic [15:0] p_peak       = '0;
  logic        p_checked    = 1'b0;
  logic        p_confirming = 1'b0;
  logic [31:0] p_confirm_t  = '0;
  logic        p_armed      = 1'b0;

  motor_stall_detector DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // next detector status for one beat; advances the predictor state
  function automatic result_t detector_step(logic op, logic [15:0] cur, logic [31:0] now);
    logic [31:0]            elapsed;
    logic [31:0]            held;
    logic [STATUS_BITS-1:0] st;
    logic                   settled;
    result_t                r;
    st      = ST_RUNNING;
    settled = 1'b0;
    if (op == OP_START) begin
      p_start      = now;
      p_peak       = '0;
      p_checked    = 1'b0;
      p_confirming = 1'b0;
      p_confirm_t  = '0;
      p_armed      = 1'b1;
    end else if (p_armed) begin
      elapsed = now - p_start;
      if (elapsed <= cfg_ignore) begin
        // startup window: peak tracking only
        if (cur > p_peak) p_peak = cur;
      end else begin
        // single motor-present check right after the window
        if (!p_checked) begin
          p_checked = 1'b1;
          if (p_peak < cfg_detect) begin
            p_armed = 1'b0;
            st      = ST_NO_MOTOR;
            settled = 1'b1;
          end
        end
        if (!settled) begin
          if (cur > cfg_thresh) begin
            if (!p_confirming) begin
              p_confirming = 1'b1;
              p_confirm_t  = now;
            end else begin
              held = now - p_confirm_t;
              if (held >= cfg_confirm) begin
                p_armed = 1'b0;
                st      = ST_STALL;
                settled = 1'b1;
              end
            end
          end else begin
            p_confirming = 1'b0;
          end
        end
        if (!settled && elapsed > cfg_timeout) begin
          p_armed = 1'b0;
          st      = p_confirming ? ST_TIMEOUT_STALL : ST_TIMEOUT_ERROR;
        end
      end
    end
    r.status = st;
    r.active = p_armed;
    return r;
  endfunction

  function automatic beat_t mk_beat(logic op, logic [CUR_BITS-1:0] cur,
                                    logic [NOW_BITS-1:0] now);
    beat_t b;
    b     = '0;
    b.op  = op;
    b.cur = cur;
    b.now = now;
    return b;
  endfunction

  // mostly near the thresholds, with full-scale and rail values mixed in
  function automatic logic [CUR_BITS-1:0] pick_current();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'hFFFF;
    else if (r < 14) return '0;
    else if (r < 30) return 16'($urandom);
    else return 16'($urandom_range(0, 1200));
  endfunction

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_STARTUP_IGNORE:  cfg_ignore  = val;
      REG_MOTOR_DETECT:    cfg_detect  = val[15:0];
      REG_STALL_THRESHOLD: cfg_thresh  = val[15:0];
      REG_STALL_CONFIRM:   cfg_confirm = val;
      REG_TIMEOUT:         cfg_timeout = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // 16-bit registers get random upper data bits, which must be dropped
  task automatic set_config(input logic [31:0] ignore, input logic [15:0] detect,
                            input logic [15:0] thresh, input logic [31:0] confirm,
                            input logic [31:0] tmo);
    write_reg(REG_STARTUP_IGNORE, ignore);
    write_reg(REG_MOTOR_DETECT, {16'($urandom), detect});
    write_reg(REG_STALL_THRESHOLD, {16'($urandom), thresh});
    write_reg(REG_STALL_CONFIRM, confirm);
    write_reg(REG_TIMEOUT, tmo);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (send_q.size() != 0 || s_tvalid || pending_status.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s: expected status %0d active %0d, got status %0d active %0d",
               $realtime, what, want.status, want.active, got.status, got.active);
  endtask

  // input driver: offer the next beat once the current one is taken
  initial begin
    beat_t nxt;
    forever begin
      @(posedge clk);
      if (!s_tvalid || s_tready) begin
        if (send_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = send_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.op;
          s_tdata  <= {nxt.now, nxt.cur};
          cur_beat <= nxt;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_go && hold_cnt < HOLD_CYCLES) begin
        hold_cnt++;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // scoreboard: check result beats, then predict for accepted input beats
  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    result_t pred;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[2:0];
        got.active = m_tdata[3];
        if (pending_status.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, got);
        end else begin
          want = pending_status.pop_front();
          if (got.status !== want.status || got.active !== want.active)
            flag_mismatch("result mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        pred = detector_step(cur_beat.op, cur_beat.cur, cur_beat.now);
        if (cur_beat.typed) begin
          want.status = cur_beat.exp_status;
          want.active = cur_beat.exp_active;
          pending_status.push_back(want);
        end else begin
          pending_status.push_back(pred);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          n;
    int          k;
    logic [31:0] t;

    // directed rows under ignore 10, detect 100, threshold 500, confirm 5, timeout 50
    dir_tab = '{
      // samples while idle after reset
      '{OP_SAMPLE, 16'hFFFF, 32'h0000_0000, 1'b1, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'h0000, 32'hFFFF_FFFF, 1'b1, ST_RUNNING, 1'b0},
      // start just below the wrap, then a stall confirmed after it
      '{OP_START,  16'hFFFF, 32'hFFFF_FFF0, 1'b1, ST_RUNNING, 1'b1},
      '{OP_SAMPLE, 16'h0000, 32'hFFFF_FFF5, 1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFA, 1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd200,  32'h0000_0004, 1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd600,  32'h0000_0005, 1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd600,  32'h0000_000A, 1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd600,  32'h0000_000B, 1'b1, ST_RUNNING, 1'b0},
      // low startup peak: no motor
      '{OP_START,  16'h0000, 32'd100,       1'b1, ST_RUNNING, 1'b1},
      '{OP_SAMPLE, 16'd50,   32'd105,       1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'h0000, 32'd111,       1'b1, ST_NO_MOTOR, 1'b0},
      // restart while armed, then timeout with confirmation pending
      '{OP_START,  16'hFFFF, 32'd200,       1'b1, ST_RUNNING, 1'b1},
      '{OP_SAMPLE, 16'd300,  32'd205,       1'b0, ST_RUNNING, 1'b0},
      '{OP_START,  16'h0000, 32'd300,       1'b1, ST_RUNNING, 1'b1},
      '{OP_SAMPLE, 16'd150,  32'd305,       1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd700,  32'd349,       1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd700,  32'd351,       1'b0, ST_RUNNING, 1'b0},
      // timeout with no confirmation pending
      '{OP_START,  16'h0000, 32'd400,       1'b1, ST_RUNNING, 1'b1},
      '{OP_SAMPLE, 16'd150,  32'd405,       1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd100,  32'd460,       1'b0, ST_RUNNING, 1'b0},
      // top timestamp, current at threshold is not above it
      '{OP_START,  16'h0000, 32'hFFFF_FFFF, 1'b1, ST_RUNNING, 1'b1},
      '{OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, ST_RUNNING, 1'b0},
      '{OP_SAMPLE, 16'd500,  32'h0000_000B, 1'b0, ST_RUNNING, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_config(32'd10, 16'd100, 16'd500, 32'd5, 32'd50);
    for (int i = 0; i < DIR_ROWS; i++) send_q.push_back(dir_tab[i]);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config('0, '0, '0, '0, '0);
        1: set_config('1, '1, '1, '1, '1);
        2: set_config('0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_config('0, '0, '0, 32'hFFFF_FFFF, 32'd20);
        default: set_config($urandom_range(0, 30), 16'($urandom_range(0, 800)),
                            16'($urandom_range(0, 900)), $urandom_range(0, 25),
                            $urandom_range(0, 120));
      endcase

      case (ph % 4)
        0: begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
        1: begin src_idle_pct <= 86; snk_stall_pct <= 0;  end
        2: begin src_idle_pct <= 0;  snk_stall_pct <= 86; end
        default: begin src_idle_pct <= 10; snk_stall_pct <= 10; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 4) hold_go <= 1'b1;

      n = 0;
      while (n < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 85) begin
          // well-formed run: start, then samples with small forward steps
          if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 60);
          else t = $urandom;
          send_q.push_back(mk_beat(OP_START, 16'($urandom), t));
          n++;
          k = $urandom_range(3, 15);
          repeat (k) begin
            if ($urandom_range(0, 99) < 3) t = $urandom;
            else t = t + $urandom_range(0, 12);
            send_q.push_back(mk_beat(OP_SAMPLE, pick_current(), t));
            n++;
          end
        end else begin
          // noise beat
          send_q.push_back(mk_beat(1'($urandom), pick_current(), $urandom));
          n++;
        end
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (pending_status.size() != 0) begin
      mismatch_cnt++;
      $display("%0d expected result beats never arrived", pending_status.size());
    end
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
